### sv/flha_pkg.sv
// Shared constants, types and micro-operation codes of the free-list heap allocator.
package flha_pkg;

    // Heap geometry.
    localparam int HEAP_BYTES   = 65536;
    localparam int HEADER_BYTES = 8;
    localparam int WORDS        = HEAP_BYTES / 4;
    localparam int WALK_LIMIT   = WORDS + 2;

    // Widths: an offset holds the whole heap range plus the sentinel code.
    localparam int OFF_W  = $clog2(HEAP_BYTES) + 1;
    localparam int IDX_W  = $clog2(WORDS);
    localparam int CNT_W  = $clog2(WALK_LIMIT);
    localparam int ADDR_W = 16;
    localparam int WORD_W = 32;

    typedef logic [OFF_W-1:0]  t_off;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [WORD_W-1:0] t_word;

    localparam t_off SENT = t_off'(HEAP_BYTES);

    // Operation codes of an item; the last code does nothing.
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_REALLOC = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    // Micro-operations issued by the controller to the datapath.
    typedef logic [4:0] t_uop;
    localparam t_uop U_NOP      = 5'd0;
    localparam t_uop U_INIT0    = 5'd1;
    localparam t_uop U_INIT1    = 5'd2;
    localparam t_uop U_ACCEPT   = 5'd3;
    localparam t_uop U_SET_FAIL = 5'd4;
    localparam t_uop U_R_FETCH  = 5'd5;
    localparam t_uop U_R_SZ     = 5'd6;
    localparam t_uop U_R_SAME   = 5'd7;
    localparam t_uop U_R_SH1    = 5'd8;
    localparam t_uop U_R_SH2    = 5'd9;
    localparam t_uop U_R_SH3    = 5'd10;
    localparam t_uop U_R_SH4    = 5'd11;
    localparam t_uop U_A_START  = 5'd12;
    localparam t_uop U_A_FIRST  = 5'd13;
    localparam t_uop U_A_STEP   = 5'd14;
    localparam t_uop U_A_UNLINK = 5'd15;
    localparam t_uop U_A_CARVE  = 5'd16;
    localparam t_uop U_A_CARVE2 = 5'd17;
    localparam t_uop U_A_FAIL   = 5'd18;
    localparam t_uop U_G_OK     = 5'd19;
    localparam t_uop U_F_START  = 5'd20;
    localparam t_uop U_F_STEP   = 5'd21;
    localparam t_uop U_F_FOUND  = 5'd22;
    localparam t_uop U_F_H      = 5'd23;
    localparam t_uop U_F_N      = 5'd24;
    localparam t_uop U_F_HSZ    = 5'd25;
    localparam t_uop U_F_HNX    = 5'd26;
    localparam t_uop U_F_DSZ    = 5'd27;
    localparam t_uop U_F_DNX    = 5'd28;
    localparam t_uop U_OUT      = 5'd29;

    // Status returned by the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       old_zero;
        logic       n_zero;
        logic       addr_ok;
        logic       sz_eq;
        logic       sz_gt;
        logic       shrink_ok;
        logic       a_fit;
        logic       a_unlink;
        logic       a_at_rover;
        logic       walk_end;
        logic       f_hit;
        logic       out_free;
    } t_stat;

endpackage

### sv/flha_dpath.sv
// Datapath of the allocator: heap memory, list pointers, arithmetic and result registers.
module flha_dpath
    import flha_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_uop              i_uop,
    input  logic [1:0]        i_opcode,
    input  logic [ADDR_W-1:0] i_old_address,
    input  logic [ADDR_W-1:0] i_request_bytes,
    input  logic              i_stall,
    output t_stat             o_st,
    output logic              o_valid,
    output logic [ADDR_W-1:0] o_result_address,
    output logic              o_status,
    output logic [ADDR_W-1:0] o_copy_bytes
);

    // Heap words, two read ports and one write port.
    t_word mem [WORDS];
    t_word r_q0, r_q1;
    logic  r_fsent;

    // List state and working registers.
    t_off              r_rover, r_snext;
    logic [1:0]        r_op;
    logic [ADDR_W-1:0] r_old;
    t_off              r_n;
    t_off              r_prev, r_cur, r_d, r_h, r_nn, r_hnx;
    t_word             r_rem, r_sz, r_hsz, r_dsz, r_nsz;
    logic [CNT_W-1:0]  r_i;
    logic              r_thn, r_tdh;
    logic [ADDR_W-1:0] r_res, r_copy;
    logic              r_status;
    logic              r_o_valid;
    logic [ADDR_W-1:0] r_o_res, r_o_copy;
    logic              r_o_status;

    logic              fetch;
    t_off              fa;
    t_idx              ra0, ra1;
    t_word             fsz;
    t_off              fnx;
    t_word             rem_a, rr;
    t_off              xoff, ext_off, n_round;
    logic [OFF_W:0]    ext;
    logic              hit, touch_hn, touch_dh;
    logic              ws_en, wn_en;
    t_off              ws_c, wn_c;
    t_word             ws_v, wn_v;
    logic              w_en;
    t_idx              w_idx;
    t_word             w_data;

    // A next offset at or beyond the heap end means the sentinel.
    function automatic t_off clamp_off(input t_word v);
        return (v >= t_word'(HEAP_BYTES)) ? SENT : v[OFF_W-1:0];
    endfunction

    // Fetched header, with the sentinel held outside the heap.
    assign fsz = r_fsent ? '0 : r_q0;
    assign fnx = r_fsent ? r_snext : clamp_off(r_q1);

    // Header fetch address for this cycle.
    always_comb begin
        fetch = 1'b0;
        fa    = r_rover;
        unique case (i_uop)
            U_A_START, U_F_START: begin
                fetch = 1'b1;
                fa    = r_rover;
            end
            U_A_FIRST, U_A_STEP, U_F_STEP: begin
                fetch = 1'b1;
                fa    = fnx;
            end
            U_F_FOUND, U_R_FETCH: begin
                fetch = 1'b1;
                fa    = r_h;
            end
            U_F_H: begin
                fetch = 1'b1;
                fa    = r_nn;
            end
            default: begin
                fetch = 1'b0;
            end
        endcase
    end

    assign ra0 = fa[IDX_W+1:2];
    assign ra1 = ra0 + 1'b1;

    // Arithmetic for carving, shrinking and merging.
    assign n_round = (t_off'(i_request_bytes) + t_off'(3)) & ~t_off'(3);
    assign rem_a   = fsz - t_word'(r_n) - t_word'(HEADER_BYTES);
    assign xoff    = {1'b0, r_cur[OFF_W-2:0] + (OFF_W-1)'(HEADER_BYTES) + r_rem[OFF_W-2:0]};
    assign rr      = r_sz - t_word'(r_n);
    assign ext     = (OFF_W+1)'(r_old) + (OFF_W+1)'(r_n);
    assign ext_off = ext[OFF_W-1:0];
    assign hit     = ((r_h > r_d) && (r_h < fnx)) ||
                     ((r_d >= fnx) && ((r_h > r_d) || (r_h < fnx)));
    assign touch_hn = (r_nn != SENT) &&
                      ((33'(r_h) + 33'(HEADER_BYTES) + 33'(r_hsz)) == 33'(r_nn));
    assign touch_dh = (r_d != SENT) &&
                      ((33'(r_d) + 33'(HEADER_BYTES) + 33'(r_dsz)) == 33'(r_h));

    // Status towards the controller.
    always_comb begin
        o_st.op         = r_op;
        o_st.old_zero   = (r_old == '0);
        o_st.n_zero     = (r_n == '0);
        o_st.addr_ok    = (r_old >= ADDR_W'(HEADER_BYTES)) &&
                          (t_off'(r_old) < SENT) && (r_old[1:0] == 2'b00);
        o_st.sz_eq      = (r_sz == t_word'(r_n));
        o_st.sz_gt      = (r_sz > t_word'(r_n));
        o_st.shrink_ok  = (r_sz > t_word'(r_n)) && (rr > t_word'(HEADER_BYTES)) &&
                          ((ext + (OFF_W+1)'(HEADER_BYTES)) < (OFF_W+1)'(HEAP_BYTES));
        o_st.a_fit      = (r_cur != SENT) && (fsz >= t_word'(r_n));
        o_st.a_unlink   = ({1'b0, fsz} < (33'(r_n) + 33'(HEADER_BYTES)));
        o_st.a_at_rover = (r_cur == r_rover);
        o_st.walk_end   = (r_i == CNT_W'(WALK_LIMIT - 1));
        o_st.f_hit      = hit;
        o_st.out_free   = !r_o_valid || !i_stall;
    end

    // Header writes requested by the micro-operation: size word or next word.
    always_comb begin
        ws_en = 1'b0;
        ws_c  = r_h;
        ws_v  = '0;
        wn_en = 1'b0;
        wn_c  = r_h;
        wn_v  = '0;
        unique case (i_uop)
            U_A_UNLINK: begin
                wn_en = 1'b1;
                wn_c  = r_prev;
                wn_v  = t_word'(fnx);
            end
            U_A_CARVE: begin
                ws_en = 1'b1;
                ws_c  = r_cur;
                ws_v  = rem_a;
            end
            U_A_CARVE2: begin
                ws_en = 1'b1;
                ws_c  = xoff;
                ws_v  = t_word'(r_n);
            end
            U_R_SH1: begin
                ws_en = 1'b1;
                ws_c  = ext_off;
                ws_v  = rr - t_word'(HEADER_BYTES);
            end
            U_R_SH2: begin
                wn_en = 1'b1;
                wn_c  = ext_off;
                wn_v  = t_word'(r_hnx);
            end
            U_R_SH3: begin
                ws_en = 1'b1;
                ws_c  = r_h;
                ws_v  = t_word'(r_n);
            end
            U_R_SH4: begin
                wn_en = 1'b1;
                wn_c  = r_h;
                wn_v  = t_word'(ext_off);
            end
            U_F_HSZ: begin
                ws_en = r_thn;
                ws_c  = r_h;
                ws_v  = r_hsz + r_nsz + t_word'(HEADER_BYTES);
            end
            U_F_HNX: begin
                wn_en = 1'b1;
                wn_c  = r_h;
                wn_v  = t_word'(r_hnx);
            end
            U_F_DSZ: begin
                ws_en = touch_dh;
                ws_c  = r_d;
                ws_v  = r_dsz + r_hsz + t_word'(HEADER_BYTES);
            end
            U_F_DNX: begin
                wn_en = 1'b1;
                wn_c  = r_d;
                wn_v  = r_tdh ? t_word'(r_hnx) : t_word'(r_h);
            end
            default: begin
                ws_en = 1'b0;
            end
        endcase
    end

    // Memory write port; the sentinel header lives in registers instead.
    always_comb begin
        w_en   = 1'b0;
        w_idx  = '0;
        w_data = '0;
        priority if (i_uop == U_INIT0) begin
            w_en   = 1'b1;
            w_idx  = t_idx'(0);
            w_data = t_word'(HEAP_BYTES - HEADER_BYTES);
        end else if (i_uop == U_INIT1) begin
            w_en   = 1'b1;
            w_idx  = t_idx'(1);
            w_data = t_word'(SENT);
        end else if (ws_en && (ws_c != SENT)) begin
            w_en   = 1'b1;
            w_idx  = ws_c[IDX_W+1:2];
            w_data = ws_v;
        end else if (wn_en && (wn_c != SENT)) begin
            w_en   = 1'b1;
            w_idx  = wn_c[IDX_W+1:2] + 1'b1;
            w_data = t_word'(clamp_off(wn_v));
        end else begin
            w_en   = 1'b0;
        end
    end

    // Heap memory.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_idx] <= w_data;
        end
        if (fetch) begin
            r_q0    <= mem[ra0];
            r_q1    <= mem[ra1];
            r_fsent <= (fa == SENT);
        end
    end

    // List head registers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rover   <= SENT;
            r_snext   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (wn_en && (wn_c == SENT)) begin
                r_snext <= clamp_off(wn_v);
            end
            if ((i_uop == U_A_UNLINK) || (i_uop == U_A_CARVE)) begin
                r_rover <= r_prev;
            end else if (i_uop == U_F_DNX) begin
                r_rover <= r_d;
            end
            if (i_uop == U_OUT) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Working registers, loaded per micro-operation.
    always_ff @(posedge i_clk) begin
        unique case (i_uop)
            U_ACCEPT: begin
                r_op     <= i_opcode;
                r_old    <= i_old_address;
                r_n      <= n_round;
                r_h      <= t_off'(i_old_address) - t_off'(HEADER_BYTES);
                r_res    <= '0;
                r_status <= 1'b0;
                r_copy   <= '0;
            end
            U_SET_FAIL: begin
                r_status <= 1'b1;
            end
            U_R_SZ: begin
                r_sz  <= fsz;
                r_hnx <= fnx;
            end
            U_R_SAME: begin
                r_res <= r_old;
            end
            U_R_SH4: begin
                r_h <= ext_off;
            end
            U_A_START: begin
                r_prev <= r_rover;
                r_i    <= '0;
            end
            U_A_FIRST: begin
                r_cur <= fnx;
            end
            U_A_STEP: begin
                r_prev <= r_cur;
                r_cur  <= fnx;
                r_i    <= r_i + 1'b1;
            end
            U_A_UNLINK: begin
                r_res <= ADDR_W'(r_cur + t_off'(HEADER_BYTES));
            end
            U_A_CARVE: begin
                r_rem <= rem_a;
            end
            U_A_CARVE2: begin
                r_res <= ADDR_W'(xoff + t_off'(HEADER_BYTES));
            end
            U_A_FAIL: begin
                r_res    <= '0;
                r_status <= 1'b1;
            end
            U_G_OK: begin
                r_copy <= r_sz[ADDR_W-1:0];
            end
            U_F_START: begin
                r_d <= r_rover;
                r_i <= '0;
            end
            U_F_STEP: begin
                r_d <= fnx;
                r_i <= r_i + 1'b1;
            end
            U_F_FOUND: begin
                r_nn  <= fnx;
                r_dsz <= fsz;
            end
            U_F_H: begin
                r_hsz <= fsz;
            end
            U_F_N: begin
                r_nsz <= fsz;
                r_thn <= touch_hn;
                r_hnx <= touch_hn ? fnx : r_nn;
            end
            U_F_HSZ: begin
                if (r_thn) begin
                    r_hsz <= ws_v;
                end
            end
            U_F_DSZ: begin
                r_tdh <= touch_dh;
            end
            U_OUT: begin
                r_o_res    <= r_res;
                r_o_status <= r_status;
                r_o_copy   <= r_copy;
            end
            default: begin
                r_tdh <= r_tdh;
            end
        endcase
    end

    assign o_valid          = r_o_valid;
    assign o_result_address = r_o_res;
    assign o_status         = r_o_status;
    assign o_copy_bytes     = r_o_copy;

`ifndef SYNTHESIS
    // The sentinel and rover pointers never leave the offset range.
    a_snext_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_snext <= SENT) else $error("sentinel next out of range");
    a_rover_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rover <= SENT) else $error("rover out of range");
    // A result appears only after the controller loads it.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(i_uop == U_OUT)) else $error("result without load");
    // A failed result carries a null address and no copy.
    a_fail_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status) |-> ((r_o_res == '0) && (r_o_copy == '0)))
        else $error("failed result not null");
`endif

endmodule

### sv/flha_ctrl.sv
// Controller state machine of the allocator: sequences list walks and header updates.
module flha_ctrl
    import flha_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_stat i_st,
    output t_uop  o_uop
);

    localparam logic [4:0] S_INIT0   = 5'd0;
    localparam logic [4:0] S_INIT1   = 5'd1;
    localparam logic [4:0] S_IDLE    = 5'd2;
    localparam logic [4:0] S_DISP    = 5'd3;
    localparam logic [4:0] S_R_SZ    = 5'd4;
    localparam logic [4:0] S_R_DEC   = 5'd5;
    localparam logic [4:0] S_SH1     = 5'd6;
    localparam logic [4:0] S_SH2     = 5'd7;
    localparam logic [4:0] S_SH3     = 5'd8;
    localparam logic [4:0] S_SH4     = 5'd9;
    localparam logic [4:0] S_A_START = 5'd10;
    localparam logic [4:0] S_A_FIRST = 5'd11;
    localparam logic [4:0] S_A_EVAL  = 5'd12;
    localparam logic [4:0] S_A_CARVE = 5'd13;
    localparam logic [4:0] S_G_OK    = 5'd14;
    localparam logic [4:0] S_F_START = 5'd15;
    localparam logic [4:0] S_F_EVAL  = 5'd16;
    localparam logic [4:0] S_F_H     = 5'd17;
    localparam logic [4:0] S_F_N     = 5'd18;
    localparam logic [4:0] S_F_HSZ   = 5'd19;
    localparam logic [4:0] S_F_HNX   = 5'd20;
    localparam logic [4:0] S_F_DSZ   = 5'd21;
    localparam logic [4:0] S_F_DNX   = 5'd22;
    localparam logic [4:0] S_OUT     = 5'd23;

    logic [4:0] r_state, n_state;
    logic       r_grow, n_grow;

    // Next state and micro-operation.
    always_comb begin
        n_state = r_state;
        n_grow  = r_grow;
        o_uop   = U_NOP;
        unique case (r_state)
            S_INIT0: begin
                o_uop   = U_INIT0;
                n_state = S_INIT1;
            end
            S_INIT1: begin
                o_uop   = U_INIT1;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_uop   = U_ACCEPT;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_grow = 1'b0;
                priority if ((i_st.op == OP_ALLOC) ||
                             ((i_st.op == OP_REALLOC) && i_st.old_zero)) begin
                    n_state = i_st.n_zero ? S_OUT : S_A_START;
                end else if (i_st.op == OP_FREE) begin
                    n_state = i_st.addr_ok ? S_F_START : S_OUT;
                end else if (i_st.op == OP_REALLOC) begin
                    if (i_st.addr_ok) begin
                        o_uop   = U_R_FETCH;
                        n_state = S_R_SZ;
                    end else begin
                        o_uop   = U_SET_FAIL;
                        n_state = S_OUT;
                    end
                end else begin
                    n_state = S_OUT;
                end
            end
            S_R_SZ: begin
                o_uop   = U_R_SZ;
                n_state = S_R_DEC;
            end
            S_R_DEC: begin
                priority if (i_st.n_zero) begin
                    n_state = S_F_START;
                end else if (i_st.sz_eq) begin
                    o_uop   = U_R_SAME;
                    n_state = S_OUT;
                end else if (i_st.sz_gt) begin
                    o_uop   = U_R_SAME;
                    n_state = i_st.shrink_ok ? S_SH1 : S_OUT;
                end else begin
                    n_grow  = 1'b1;
                    n_state = S_A_START;
                end
            end
            S_SH1: begin
                o_uop   = U_R_SH1;
                n_state = S_SH2;
            end
            S_SH2: begin
                o_uop   = U_R_SH2;
                n_state = S_SH3;
            end
            S_SH3: begin
                o_uop   = U_R_SH3;
                n_state = S_SH4;
            end
            S_SH4: begin
                o_uop   = U_R_SH4;
                n_state = S_F_START;
            end
            S_A_START: begin
                o_uop   = U_A_START;
                n_state = S_A_FIRST;
            end
            S_A_FIRST: begin
                o_uop   = U_A_FIRST;
                n_state = S_A_EVAL;
            end
            // One free chunk examined per cycle.
            S_A_EVAL: begin
                priority if (i_st.a_fit) begin
                    if (i_st.a_unlink) begin
                        o_uop   = U_A_UNLINK;
                        n_state = r_grow ? S_G_OK : S_OUT;
                    end else begin
                        o_uop   = U_A_CARVE;
                        n_state = S_A_CARVE;
                    end
                end else if (i_st.a_at_rover || i_st.walk_end) begin
                    o_uop   = U_A_FAIL;
                    n_state = S_OUT;
                end else begin
                    o_uop = U_A_STEP;
                end
            end
            S_A_CARVE: begin
                o_uop   = U_A_CARVE2;
                n_state = r_grow ? S_G_OK : S_OUT;
            end
            S_G_OK: begin
                o_uop   = U_G_OK;
                n_state = S_F_START;
            end
            S_F_START: begin
                o_uop   = U_F_START;
                n_state = S_F_EVAL;
            end
            // One list link examined per cycle while seeking the insertion point.
            S_F_EVAL: begin
                priority if (i_st.f_hit) begin
                    o_uop   = U_F_FOUND;
                    n_state = S_F_H;
                end else if (i_st.walk_end) begin
                    n_state = S_OUT;
                end else begin
                    o_uop = U_F_STEP;
                end
            end
            S_F_H: begin
                o_uop   = U_F_H;
                n_state = S_F_N;
            end
            S_F_N: begin
                o_uop   = U_F_N;
                n_state = S_F_HSZ;
            end
            S_F_HSZ: begin
                o_uop   = U_F_HSZ;
                n_state = S_F_HNX;
            end
            S_F_HNX: begin
                o_uop   = U_F_HNX;
                n_state = S_F_DSZ;
            end
            S_F_DSZ: begin
                o_uop   = U_F_DSZ;
                n_state = S_F_DNX;
            end
            S_F_DNX: begin
                o_uop   = U_F_DNX;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_st.out_free) begin
                    o_uop   = U_OUT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT0;
            r_grow  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_grow  <= n_grow;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

### sv/free_list_heap_allocator.sv
// Top level of the next-fit free-list heap allocator.
// One item at a time. Allocate walks the free chunks until one fits;
// free walks the list links to the insertion point; a grow does both.
// The walk is set by the single heap memory, one header fetched per cycle,
// and stops after at most 16386 links.
// After reset the states S_INIT0 and S_INIT1 write the initial free header before the first item is taken.
module free_list_heap_allocator
    import flha_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_opcode,
    input  logic [ADDR_W-1:0] i_old_address,
    input  logic [ADDR_W-1:0] i_request_bytes,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [ADDR_W-1:0] o_result_address,
    output logic              o_status,
    output logic [ADDR_W-1:0] o_copy_bytes
);

    t_uop  uop;
    t_stat st;

    // Sequencer.
    flha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_st    (st),
        .o_uop   (uop)
    );

    // Heap memory and arithmetic.
    flha_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_uop            (uop),
        .i_opcode         (i_opcode),
        .i_old_address    (i_old_address),
        .i_request_bytes  (i_request_bytes),
        .i_stall          (i_stall),
        .o_st             (st),
        .o_valid          (o_valid),
        .o_result_address (o_result_address),
        .o_status         (o_status),
        .o_copy_bytes     (o_copy_bytes)
    );

endmodule
